// ===== rtl/core/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int unsigned PixW = 8;
    localparam int unsigned Planes = 3;
    localparam int unsigned Taps = 9;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned DivW = 10;
    localparam int unsigned FwW = 11;
    localparam int unsigned FhW = 13;
    localparam int unsigned ExtW = 14;
    localparam int unsigned ProdW = 17;
    localparam int unsigned SumW = 20;
    localparam int unsigned MagW = 19;
    localparam int unsigned StepW = 5;

    localparam logic [CfgDataW-1:0] CoefTopRst = 24'd0;
    localparam logic [CfgDataW-1:0] CoefMidRst = 24'd256;
    localparam logic [CfgDataW-1:0] CoefBotRst = 24'd0;
    localparam logic [DivW-1:0] DivRst = 10'd1;
    localparam logic [FwW-1:0] FwRst = 11'd1024;
    localparam logic [FhW-1:0] FhRst = 13'd1024;

    typedef enum logic [CfgIdxW-1:0] {
        REG_COEF_TOP = 3'd0,
        REG_COEF_MID = 3'd1,
        REG_COEF_BOT = 3'd2,
        REG_DIVISOR = 3'd3,
        REG_FRAME_W = 3'd4,
        REG_FRAME_H = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_CALC,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [PixW-1:0] blue;
        logic [PixW-1:0] green;
        logic [PixW-1:0] red;
    } pixel_in_t;

    typedef struct packed {
        logic            frame_end;
        logic [PixW-1:0] blue_out;
        logic [PixW-1:0] green_out;
        logic [PixW-1:0] red_out;
    } pixel_out_t;

    typedef struct packed {
        logic start;
    } lane_ctrl_t;

    typedef struct packed {
        logic            done;
        logic [PixW-1:0] result;
    } lane_stat_t;

endpackage

// ===== rtl/core/rgb_convolution_3x3_top.sv =====
// 3x3 convolution of an rgb pixel stream in raster order. Pixels are taken one
// request at a time; each pixel not in the first two rows or columns
// yields one result request with the three filtered planes, the result for centre
// (r-1, c-1) following the pixel (r, c); other pixels yield nothing and frame_end
// marks the last result of a frame. A pixel that gives a result goes through the
// line store read, window update, one product stage, one sum stage and a 19-step
// restoring divider in each of the three plane lanes, which work side by side.
// A finished result waits in the output register while the next pixel is taken.
// Configuration: cfg_index 0..2 are the kernel rows (signed bytes, left column in
// the low byte), 3 the divisor (0 acts as 1), 4 the frame width, 5 the frame
// height; sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT. Write them only
// while the block is idle.
module rgb_convolution_3x3_top #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rgbc_pkg::pixel_in_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rgbc_pkg::pixel_out_t             m_data,
    input  logic                             cfg_we,
    input  logic [rgbc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [rgbc_pkg::CfgDataW-1:0]    cfg_data
);
    import rgbc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned LineW = 2 * Planes * PixW;

    // configuration registers
    logic [2:0][CfgDataW-1:0] coef_reg;
    logic [DivW-1:0]          div_reg;
    logic [FwW-1:0]           fw_reg;
    logic [FhW-1:0]           fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= CoefTopRst;
            coef_reg[1] <= CoefMidRst;
            coef_reg[2] <= CoefBotRst;
            div_reg <= DivRst;
            fw_reg <= FwRst;
            fh_reg <= FhRst;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_COEF_TOP: coef_reg[0] <= cfg_data;
                REG_COEF_MID: coef_reg[1] <= cfg_data;
                REG_COEF_BOT: coef_reg[2] <= cfg_data;
                REG_DIVISOR:  div_reg <= cfg_data[DivW-1:0];
                REG_FRAME_W:  fw_reg <= cfg_data[FwW-1:0];
                REG_FRAME_H:  fh_reg <= cfg_data[FhW-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size, clamped
    logic [ExtW-1:0] w_ext;
    logic [ExtW-1:0] h_ext;
    logic [ExtW-1:0] w_eff;
    logic [ExtW-1:0] h_eff;
    logic [CW-1:0]   w_last;
    logic [RW-1:0]   h_last;
    logic [DivW-1:0] div_eff;

    assign w_ext = ExtW'(fw_reg);
    assign h_ext = ExtW'(fh_reg);

    always_comb begin
        w_eff = w_ext;
        if (w_ext < ExtW'(3)) begin
            w_eff = ExtW'(3);
        end else if (w_ext > ExtW'(MAX_WIDTH)) begin
            w_eff = ExtW'(MAX_WIDTH);
        end
        h_eff = h_ext;
        if (h_ext < ExtW'(3)) begin
            h_eff = ExtW'(3);
        end else if (h_ext > ExtW'(MAX_HEIGHT)) begin
            h_eff = ExtW'(MAX_HEIGHT);
        end
    end

    assign w_last = CW'(w_eff - ExtW'(1));
    assign h_last = RW'(h_eff - ExtW'(1));
    assign div_eff = (div_reg == '0) ? DivW'(1) : div_reg;

    // position counters
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;

    assign col_eff = (col_cnt_reg > w_last) ? w_last : col_cnt_reg;
    assign row_eff = (row_cnt_reg > h_last) ? h_last : row_cnt_reg;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   out_load;

    assign accept = s_valid && s_ready;

    // per-pixel registers captured on accept
    logic [CW-1:0] col_reg;
    logic          interior_reg;
    logic          last_reg;
    pixel_in_t     pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            if (col_eff == w_last) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (row_eff == h_last) ? '0 : row_eff + RW'(1);
            end else begin
                col_cnt_reg <= col_eff + CW'(1);
                row_cnt_reg <= row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg <= col_eff;
            pix_reg <= s_data;
            interior_reg <= (row_eff >= RW'(2)) && (col_eff >= CW'(2));
            last_reg <= (row_eff == h_last) && (col_eff == w_last);
        end
    end

    // both line stores in one memory: upper row in the high half
    logic [LineW-1:0] line_rdata;
    logic             line_we;

    assign line_we = (state_reg == ST_FETCH);

    rgbc_ram #(
        .WIDTH(LineW),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .aclk (aclk),
        .we   (line_we),
        .waddr(col_reg),
        .wdata({line_rdata[LineW/2-1:0], pix_reg}),
        .raddr(col_eff),
        .rdata(line_rdata)
    );

    // 3x3 window, rows top to bottom, columns left to right
    logic [Taps-1:0][Planes*PixW-1:0] win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (line_we) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r * 3] <= win_reg[r * 3 + 1];
                win_reg[r * 3 + 1] <= win_reg[r * 3 + 2];
            end
            win_reg[2] <= line_rdata[LineW-1:LineW/2];
            win_reg[5] <= line_rdata[LineW/2-1:0];
            win_reg[8] <= pix_reg;
        end
    end

    // one lane per colour plane
    lane_ctrl_t lane_ctrl;
    lane_stat_t lane_stat [Planes];

    assign lane_ctrl.start = (state_reg == ST_START);

    for (genvar p = 0; p < Planes; p++) begin : g_lane
        logic [Taps-1:0][PixW-1:0] plane_pix;

        always_comb begin
            for (int t = 0; t < Taps; t++) begin
                plane_pix[t] = win_reg[t][p * PixW +: PixW];
            end
        end

        rgbc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .pix      (plane_pix),
            .coef_rows(coef_reg),
            .divisor  (div_eff),
            .stat     (lane_stat[p])
        );
    end

    // control sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_FETCH;
            ST_FETCH: state_next = interior_reg ? ST_START : ST_IDLE;
            ST_START: state_next = ST_CALC;
            ST_CALC:  if (lane_stat[0].done) state_next = ST_HOLD;
            ST_HOLD:  if (!m_valid || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_HOLD: out_load = !m_valid || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // merge lane results into the output register
    logic       m_valid_reg;
    pixel_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.red_out <= lane_stat[0].result;
            m_data_reg.green_out <= lane_stat[1].result;
            m_data_reg.blue_out <= lane_stat[2].result;
            m_data_reg.frame_end <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // lanes run in lock step
    a_lanes_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_stat[0].done == lane_stat[1].done && lane_stat[0].done == lane_stat[2].done)
        else $error("plane lanes out of step");

    // lane completion only while waiting for it
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_stat[0].done |-> state_reg == ST_CALC)
        else $error("lane finished outside calc");

    // line store address stays inside the frame
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> col_reg <= w_last)
        else $error("column beyond frame");

    // an accepted pixel goes to the fetch step
    a_accept_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_FETCH)
        else $error("accept not followed by fetch");

endmodule

// ===== rtl/core/rgbc_ram.sv =====
module rgbc_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rgbc_lane.sv =====
module rgbc_lane (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  rgbc_pkg::lane_ctrl_t                     ctrl,
    input  logic [rgbc_pkg::Taps-1:0][rgbc_pkg::PixW-1:0] pix,
    input  logic [2:0][rgbc_pkg::CfgDataW-1:0]       coef_rows,
    input  logic [rgbc_pkg::DivW-1:0]                divisor,
    output rgbc_pkg::lane_stat_t                     stat
);
    import rgbc_pkg::*;

    logic signed [ProdW-1:0] prod_reg [Taps];
    logic signed [ProdW-1:0] prod_next [Taps];
    logic                    sum_go_reg;
    logic signed [SumW-1:0]  sum;
    logic [MagW-1:0]         quo_reg;
    logic [DivW-1:0]         rem_reg;
    logic [StepW-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DivW:0]           shifted;
    logic [DivW:0]           trial;

    // one signed product per tap: unsigned pixel by signed coefficient byte
    always_comb begin
        for (int t = 0; t < Taps; t++) begin
            prod_next[t] = $signed({1'b0, pix[t]}) *
                           $signed(coef_rows[t / 3][8 * (t % 3) +: 8]);
        end
    end

    always_comb begin
        sum = '0;
        for (int t = 0; t < Taps; t++) begin
            sum = sum + SumW'(prod_reg[t]);
        end
    end

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[MagW-1]};
    assign trial = shifted - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            for (int t = 0; t < Taps; t++) begin
                prod_reg[t] <= prod_next[t];
            end
        end
        if (sum_go_reg) begin
            // a negative sum clamps to zero whatever the quotient
            quo_reg <= sum[SumW-1] ? '0 : sum[MagW-1:0];
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!trial[DivW]) begin
                rem_reg <= trial[DivW-1:0];
                quo_reg <= {quo_reg[MagW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DivW-1:0];
                quo_reg <= {quo_reg[MagW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_go_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            sum_go_reg <= ctrl.start;
            done_reg <= busy_reg && (cnt_reg == StepW'(1));
            if (sum_go_reg) begin
                busy_reg <= 1'b1;
                cnt_reg <= StepW'(MagW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - StepW'(1);
                if (cnt_reg == StepW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.result = (quo_reg > MagW'(255)) ? 8'd255 : quo_reg[PixW-1:0];

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned SETTLE_CYCLES = 40;

    // convolution predictor and expected result store
    class conv_scoreboard;
        logic [23:0] upper_row [1024];
        logic [23:0] lower_row [1024];
        logic [23:0] win [9];
        int unsigned col_cnt;
        int unsigned row_cnt;
        logic [23:0] kern [3];
        logic [DivW-1:0] div_reg;
        logic [FwW-1:0] width_reg;
        logic [FhW-1:0] height_reg;
        pixel_out_t expected_q [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned pixels_seen;

        function new();
            kern[0] = CoefTopRst;
            kern[1] = CoefMidRst;
            kern[2] = CoefBotRst;
            div_reg = DivRst;
            width_reg = FwRst;
            height_reg = FhRst;
            col_cnt = 0;
            row_cnt = 0;
            foreach (win[i]) win[i] = '0;
            mismatches = 0;
            results_seen = 0;
            pixels_seen = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_COEF_TOP: kern[0] = val;
                REG_COEF_MID: kern[1] = val;
                REG_COEF_BOT: kern[2] = val;
                REG_DIVISOR: div_reg = val[DivW-1:0];
                REG_FRAME_W: width_reg = val[FwW-1:0];
                REG_FRAME_H: height_reg = val[FhW-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > 1024) w = 1024;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < 3) h = 3;
            if (h > 4096) h = 4096;
            return h;
        endfunction

        function logic [7:0] filter(int unsigned shift, int dv);
            int acc;
            logic [7:0] cb;
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    cb = kern[r][8*c +: 8];
                    acc += int'(win[r*3+c][shift +: 8]) * int'($signed(cb));
                end
            end
            acc = acc / dv;
            if (acc < 0) acc = 0;
            else if (acc > 255) acc = 255;
            return acc[7:0];
        endfunction

        function void note_pixel(pixel_in_t px);
            int unsigned w, h, col, row;
            int dv;
            logic [23:0] pv;
            pixel_out_t exp_res;
            w = eff_width();
            h = eff_height();
            dv = (div_reg == 0) ? 1 : int'(div_reg);
            pv = {px.blue, px.green, px.red};
            col = (col_cnt >= w) ? w - 1 : col_cnt;
            row = (row_cnt >= h) ? h - 1 : row_cnt;
            for (int r = 0; r < 3; r++) begin
                win[r*3] = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = upper_row[col];
            win[5] = lower_row[col];
            win[8] = pv;
            upper_row[col] = lower_row[col];
            lower_row[col] = pv;
            pixels_seen++;
            if (row >= 2 && col >= 2) begin
                exp_res.red_out = filter(0, dv);
                exp_res.green_out = filter(8, dv);
                exp_res.blue_out = filter(16, dv);
                exp_res.frame_end = (row == h - 1 && col == w - 1);
                expected_q.push_back(exp_res);
            end
            if (col + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col_cnt = col + 1;
                row_cnt = row;
            end
        endfunction

        function void check_result(pixel_out_t act);
            pixel_out_t exp_res;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", act);
                return;
            end
            exp_res = expected_q.pop_front();
            if (act.red_out !== exp_res.red_out || act.green_out !== exp_res.green_out ||
                act.blue_out !== exp_res.blue_out || act.frame_end !== exp_res.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                             results_seen, exp_res.red_out, exp_res.green_out, exp_res.blue_out,
                             exp_res.frame_end, act.red_out, act.green_out, act.blue_out,
                             act.frame_end);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    pixel_in_t s_data;
    logic m_valid;
    logic m_ready;
    pixel_out_t m_data;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    conv_scoreboard sb;
    bit src_idle_on;      // random gaps on the pixel side
    bit sink_stall_on;    // random stalls on the result side
    int unsigned cycle_cnt;
    int unsigned settings_cnt;

    rgb_convolution_3x3_top uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result monitor, sampled on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result-side backpressure: random stall bursts, between runs of ready
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stall_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
        end
    end

    // register write; called at a falling edge, returns at the next one
    task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic write_kernel(logic [23:0] top, logic [23:0] mid, logic [23:0] bot,
                                logic [CfgDataW-1:0] dv);
        write_reg(REG_COEF_TOP, top);
        write_reg(REG_COEF_MID, mid);
        write_reg(REG_COEF_BOT, bot);
        write_reg(REG_DIVISOR, dv);
        cfg_we <= 1'b0;
        @(negedge aclk);
        settings_cnt++;
    endtask

    task automatic write_size(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h);
        write_reg(REG_FRAME_W, w);
        write_reg(REG_FRAME_H, h);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // one pixel request, optionally preceded by a gap
    task automatic send_pixel(pixel_in_t px);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pixel(px);
        @(negedge aclk);
    endtask

    // drain outstanding results, then let the block settle before reconfiguring
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_plane();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_in_t rand_pixel();
        pixel_in_t px;
        px.red = rand_plane();
        px.green = rand_plane();
        px.blue = rand_plane();
        return px;
    endfunction

    function automatic logic [23:0] rand_kernel_row();
        logic [23:0] row;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0: row[8*k +: 8] = 8'h7f;
                1: row[8*k +: 8] = 8'h80;
                2: row[8*k +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
                default: row[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return row;
    endfunction

    function automatic logic [CfgDataW-1:0] rand_divisor();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return 1023;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    task automatic send_rows(int unsigned nrows);
        repeat (nrows * sb.eff_width()) send_pixel(rand_pixel());
    endtask

    task automatic random_kernel();
        write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), rand_divisor());
    endtask

    initial begin
        pixel_in_t px;
        sb = new();
        cycle_cnt = 0;
        settings_cnt = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_COEF_TOP;
        cfg_data = '0;
        src_idle_on = 1'b0;
        sink_stall_on = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: smallest frame, positive saturation with all-max kernel
        write_size(3, 3);
        write_kernel(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 1);
        px = '{blue: 8'd255, green: 8'd255, red: 8'd255};
        repeat (9) send_pixel(px);
        wait_idle();
        // directed: negative saturation, most negative kernel, max divisor
        write_kernel(24'h808080, 24'h808080, 24'h808080, 1023);
        repeat (9) send_pixel(px);
        wait_idle();
        // directed: zero divisor and out-of-range sizes clamp to the minimum
        write_size(0, 0);
        write_kernel(24'h010101, 24'h010101, 24'h010101, 0);
        px = '0;
        repeat (4) send_pixel(px);
        px = '{blue: 8'd255, green: 8'd0, red: 8'd128};
        repeat (5) send_pixel(px);
        wait_idle();

        src_idle_on = 1'b1;
        sink_stall_on = 1'b1;

        // random small frames, varied kernels and sizes
        while (sb.pixels_seen < 350) begin
            write_size($urandom_range(3, 12), $urandom_range(3, 8));
            random_kernel();
            repeat ($urandom_range(1, 2)) send_rows(sb.eff_height());
            wait_idle();
        end

        // wider frame with a sharpening kernel
        write_size(64, 3);
        write_kernel(24'h00ff00, 24'hff08ff, 24'h00ff00, 4);
        send_rows(3);
        wait_idle();

        // tall frame cut short by shrinking the height mid-frame
        write_size(3, 8191);
        random_kernel();
        send_rows(30);
        wait_idle();
        write_size(3, 3);
        send_rows(1);
        send_rows(3);
        wait_idle();

        // closing part with no gaps or stalls
        src_idle_on = 1'b0;
        sink_stall_on = 1'b0;
        wait_idle();
        write_size(6, 4);
        random_kernel();
        send_rows(8);
        wait_idle();

        $display("covered %0d pixel requests, %0d results, %0d kernel settings",
                 sb.pixels_seen, sb.results_seen, settings_cnt);
        $display("frame sizes from 3x3 to 64x3, a cut-short tall frame, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
